// ----- sv/bba_pkg.sv -----
// Shared constants, types and helpers of the bitmap block allocator.
package bba_pkg;

  localparam int unsigned MapBitsDefault = 1024;
  localparam int unsigned ItemW          = 11;
  localparam int unsigned MapBytesW      = 8;
  localparam int unsigned WordBits       = 32;
  localparam int unsigned WordLsb        = $clog2(WordBits);
  localparam int unsigned LimitCap       = (2**MapBytesW - 1) * 8;
  localparam int unsigned MapBytesReset  = 128;
  localparam int unsigned ApbAddrW       = 3;
  localparam int unsigned ApbDataW       = 32;
  localparam int unsigned RegIdxLsb      = 2;

  localparam logic RegMapBytes = 1'b0;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef enum logic [1:0] {
    StChanged  = 2'd0,
    StRange    = 2'd1,
    StNoChange = 2'd2
  } bba_status_e;

  function automatic logic [ItemW-1:0] bba_limit(input logic [MapBytesW-1:0] map_bytes,
                                                 input logic [ItemW-1:0] max_limit);
    logic [MapBytesW-1:0] bytes;
    logic [ItemW-1:0]     lim;
    bytes = (map_bytes == '0) ? MapBytesW'(1) : map_bytes;
    lim   = {bytes, 3'b000};
    return (lim > max_limit) ? max_limit : lim;
  endfunction

endpackage

// ----- sv/bba_map_mem.sv -----
// Word-organized bitmap memory with per-word valid bits; unwritten words read as zero.
module bba_map_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [AddrW-1:0]             rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [AddrW-1:0]             wr_addr_i,
  input  logic [bba_pkg::WordBits-1:0] wr_data_i,
  output logic [bba_pkg::WordBits-1:0] rd_data_o
);
  import bba_pkg::*;

  logic [WordBits-1:0] mem [Depth];
  logic [Depth-1:0]    vld_q;
  logic [WordBits-1:0] rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- sv/bitmap_block_allocator_core.sv -----
// Top level of the bitmap block allocator: first-fit search and free count over a bitmap memory.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o | kind_i, item_number_i
//  out     | output    | out_valid_o / out_stall_i | first_free_o, free_count_o, status_o
//  cfg     | input     | APB psel / penable      | paddr, pwdata, prdata
//
//  An item passes in order through bitmap word read, modify and write-back, summary search
//  with read of the first non-full word, and the in-word zero search.
//  The bitmap memory has one read port and one write port; in_stall_o stays high until the item is done.
//  A map_bytes write starts a recount that reads each memory word and then adds its free bits
//  while in_stall_o stays high. No clearing pass after reset: per-word valid bits.
//  A held result on the output stalls the next item at its final step only.
module bitmap_block_allocator_core #(
  parameter int unsigned MAP_BITS = bba_pkg::MapBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [bba_pkg::ItemW-1:0]     item_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bba_pkg::ItemW-1:0]     first_free_o,
  output logic [bba_pkg::ItemW-1:0]     free_count_o,
  output logic [1:0]                    status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bba_pkg::ApbDataW-1:0]  pwdata,
  output logic [bba_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bba_pkg::*;

  localparam int unsigned MaxLimit  = (MAP_BITS < LimitCap) ? MAP_BITS : LimitCap;
  localparam int unsigned NumWords  = (MaxLimit + WordBits - 1) / WordBits;
  localparam int unsigned AddrW     = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned Depth     = 2**AddrW;
  localparam int unsigned ResetFree = (MaxLimit < MapBytesReset * 8) ? MaxLimit
                                                                     : MapBytesReset * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FIND,
    S_PICK,
    S_CNT,
    S_SUM
  } state_e;

  state_e                 state_q;
  logic [MapBytesW-1:0]   map_bytes_q;
  logic [ItemW-1:0]       lim;
  logic                   hit_q;
  logic                   kind_q;
  logic [ItemW-1:0]       idx_q;
  bba_status_e            status_q;
  logic [ItemW-1:0]       free_q;
  logic [NumWords-1:0]    full_q;
  logic [AddrW-1:0]       ff_word_q;
  logic                   ff_found_q;
  logic [AddrW-1:0]       cnt_q;
  logic [ItemW-1:0]       acc_q;
  logic                   out_valid_q;
  logic [ItemW-1:0]       first_free_q;
  logic [ItemW-1:0]       out_free_q;
  bba_status_e            out_status_q;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [ItemW-1:0]       in_idx;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic                   wr_en;
  logic [WordBits-1:0]    wr_data;
  logic [WordBits-1:0]    rd_data;
  logic [AddrW-1:0]       idx_word;
  logic                   cur_used;
  logic                   sr_found;
  logic [AddrW-1:0]       sr_word;
  logic                   zr_found;
  logic [WordLsb-1:0]     zr_bit;
  logic [ItemW:0]         cand;
  logic [ItemW-1:0]       pick_free;
  logic [WordBits-1:0]    cnt_mask;
  logic [ItemW:0]         cnt_base;

  assign lim      = bba_limit(map_bytes_q, ItemW'(MaxLimit));
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_idx   = item_number_i - ItemW'(1);
  assign idx_word = AddrW'(idx_q[ItemW-1:WordLsb]);
  assign cur_used = rd_data[idx_q[WordLsb-1:0]];

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign first_free_o = first_free_q;
  assign free_count_o = out_free_q;
  assign status_o     = out_status_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr[RegIdxLsb] == RegMapBytes) ? ApbDataW'(map_bytes_q) : '0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        rd_en   = in_acc;
        rd_addr = AddrW'(in_idx[ItemW-1:WordLsb]);
      end
      S_FIND: begin
        rd_en   = 1'b1;
        rd_addr = sr_word;
      end
      S_CNT: begin
        rd_en   = 1'b1;
        rd_addr = cnt_q;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = (state_q == S_MOD) && hit_q && (cur_used == (kind_q == KindRelease));
    wr_data = rd_data;
    wr_data[idx_q[WordLsb-1:0]] = (kind_q == KindAlloc);
  end

  always_comb begin
    sr_found = 1'b0;
    sr_word  = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (!full_q[i] && ((i * WordBits) < int'(lim))) begin
        sr_found = 1'b1;
        sr_word  = AddrW'(i);
      end
    end
  end

  always_comb begin
    zr_found = 1'b0;
    zr_bit   = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (!rd_data[b]) begin
        zr_found = 1'b1;
        zr_bit   = WordLsb'(b);
      end
    end
    cand      = (ItemW + 1)'({ff_word_q, zr_bit}) + (ItemW + 1)'(1);
    pick_free = (ff_found_q && zr_found && (cand <= {1'b0, lim})) ? ItemW'(cand) : '0;
  end

  always_comb begin
    cnt_base = (ItemW + 1)'({cnt_q, {WordLsb{1'b0}}});
    for (int b = 0; b < WordBits; b++) begin
      cnt_mask[b] = ((cnt_base + (ItemW + 1)'(b)) < {1'b0, lim});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      map_bytes_q  <= MapBytesW'(MapBytesReset);
      hit_q        <= 1'b0;
      kind_q       <= KindAlloc;
      idx_q        <= '0;
      status_q     <= StNoChange;
      free_q       <= ItemW'(ResetFree);
      full_q       <= '0;
      ff_word_q    <= '0;
      ff_found_q   <= 1'b0;
      cnt_q        <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      first_free_q <= '0;
      out_free_q   <= '0;
      out_status_q <= StNoChange;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q <= kind_i;
            idx_q  <= in_idx;
            hit_q  <= 1'b0;
            if (item_number_i == '0) begin
              status_q <= (kind_i == KindAlloc) ? StRange : StNoChange;
            end else if (item_number_i > lim) begin
              status_q <= StRange;
            end else begin
              hit_q <= 1'b1;
            end
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (hit_q) begin
            if (wr_en) begin
              status_q         <= StChanged;
              full_q[idx_word] <= (wr_data == '1);
              if (kind_q == KindAlloc) begin
                if (free_q != '0) begin
                  free_q <= free_q - ItemW'(1);
                end
              end else begin
                free_q <= free_q + ItemW'(1);
              end
            end else begin
              status_q <= StNoChange;
            end
          end
          state_q <= S_FIND;
        end
        S_FIND: begin
          ff_word_q  <= sr_word;
          ff_found_q <= sr_found;
          state_q    <= S_PICK;
        end
        S_PICK: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            first_free_q <= pick_free;
            out_free_q   <= free_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_FIND;
          end
        end
        S_CNT: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (cnt_q == AddrW'(NumWords - 1)) begin
            free_q  <= acc_q + ItemW'($countones(~rd_data & cnt_mask));
            state_q <= S_IDLE;
          end else begin
            acc_q   <= acc_q + ItemW'($countones(~rd_data & cnt_mask));
            cnt_q   <= cnt_q + AddrW'(1);
            state_q <= S_CNT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cfg_wr && (paddr[RegIdxLsb] == RegMapBytes)) begin
        map_bytes_q <= pwdata[MapBytesW-1:0];
        cnt_q       <= '0;
        acc_q       <= '0;
        state_q     <= S_CNT;
      end
    end
  end

  bba_map_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_word),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

// ----- sv/bba_checker.sv -----
// Port-level checks of the bitmap block allocator and their bind to the top level.
module bba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bba_pkg::ItemW-1:0]     first_free_o,
  input logic [bba_pkg::ItemW-1:0]     free_count_o,
  input logic [1:0]                    status_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bba_pkg::ApbAddrW-1:0]  paddr
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_free_o)
                                   && $stable(free_count_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_item_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("next transaction accepted before the current one finished");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[RegIdxLsb] == RegMapBytes) |=> in_stall_o)
    else $error("input not held off during recount");

  a_none_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (free_count_o == '0) |-> (first_free_o == '0))
    else $error("free item reported while free count is zero");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .first_free_o (first_free_o),
  .free_count_o (free_count_o),
  .status_o     (status_o),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr)
);
